// ----- rtl/dtpc_pkg.sv -----
`timescale 1ns / 1ps

package dtpc_pkg;

	// Field widths
	localparam int COEF_W      = 32;
	localparam int DEPTH_W     = 16;
	localparam int SCALE_W     = 24;
	localparam int DQ_W        = DEPTH_W + SCALE_W;	// depth in mm, Q.16
	localparam int DQ_HALF     = DQ_W / 2;
	localparam int ROW_LEN_W   = 13;
	localparam int POINT_W     = 32;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int MAX_DIM_DEF = 4096;

	// Q.44 product down to Q.8
	localparam int ROUND_SHIFT = 36;
	// Q.16 depth down to Q.8
	localparam int Z_DROP      = 8;
	localparam int Z_HALF      = 128;

	// Microprogram
	localparam int STEP_W = 3;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_RAY_COL,	// ray = coef_col * col + coef_off
		OP_RAY_ROW,	// ray += coef_row * row
		OP_MAG,		// split sign and magnitude, preload rounding half
		OP_PP_LL,
		OP_PP_LH,
		OP_PP_HL,
		OP_PP_HH
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     wait_out;	// hold this step until the result register is free
		logic     done;		// last step: jump to step 0 on a new word, else idle
	} ucode_t;

	typedef struct packed {
		lane_op_t op;
		logic     out_load;
	} seq_ctl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{op: OP_NOP, wait_out: 1'b0, done: 1'b0};
		unique case (step)
			3'd0: w.op = OP_RAY_COL;
			3'd1: w.op = OP_RAY_ROW;
			3'd2: w.op = OP_MAG;
			3'd3: w.op = OP_PP_LL;
			3'd4: w.op = OP_PP_LH;
			3'd5: w.op = OP_PP_HL;
			3'd6: w.op = OP_PP_HH;
			3'd7: begin
				w.wait_out = 1'b1;
				w.done     = 1'b1;
			end
			default: w.op = OP_NOP;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/dtpc_seq.sv -----
`timescale 1ns / 1ps

module dtpc_seq import dtpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,		// word accepted this cycle
	input  logic     out_free,	// result register can take a new value
	output logic     take_ok,	// sequencer can start a word this cycle
	output seq_ctl_t ctl
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   pc_q;
	ucode_t              cw;
	logic                go;

	assign cw      = ucode_rom(pc_q);
	assign go      = !cw.wait_out || out_free;
	assign take_ok = (state_q == ST_IDLE) || (cw.done && go);

	always_comb begin
		ctl.op       = OP_NOP;
		ctl.out_load = 1'b0;
		if (state_q == ST_RUN && go) begin
			ctl.op       = cw.op;
			ctl.out_load = cw.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						pc_q    <= '0;
					end
				end
				ST_RUN: begin
					if (go) begin
						if (cw.done) begin
							pc_q <= '0;
							if (!start)
								state_q <= ST_IDLE;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/dtpc_lane.sv -----
`timescale 1ns / 1ps

module dtpc_lane import dtpc_pkg::*; #(
	parameter int CW = 12
) (
	input  logic                      clk,
	input  lane_op_t                  op,
	input  logic signed [COEF_W-1:0]  coef_col,
	input  logic signed [COEF_W-1:0]  coef_row,
	input  logic signed [COEF_W-1:0]  coef_off,
	input  logic [CW-1:0]             col,
	input  logic [CW-1:0]             row,
	input  logic [DQ_W-1:0]           dq,
	output logic signed [POINT_W-1:0] point
);

	localparam int RW  = COEF_W + CW + 2;			// ray term, Q.28
	localparam int MH  = (RW + 1) / 2;			// low half of magnitude
	localparam int AW  = COEF_W + 1;
	localparam int BW  = ((CW > DQ_HALF) ? CW : DQ_HALF) + 1;
	localparam int PRW = AW + BW;
	localparam int PPW = MH + DQ_HALF;			// partial product width
	localparam int PW  = RW + DQ_W + 1;			// full product plus round

	logic signed [AW-1:0]  a_op;
	logic signed [BW-1:0]  b_op;
	logic signed [PRW-1:0] prod;
	logic [PW-1:0]         pp_ext;
	logic [PW-1:0]         pp_add;

	logic [RW-1:0] ray_q;
	logic [RW-1:0] mag_q;
	logic          neg_q;
	logic [PW-1:0] pp_q;

	logic                       over;
	logic [POINT_W-2:0]         r_lo;

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (op)
			OP_RAY_COL: begin
				a_op = {coef_col[COEF_W-1], coef_col};
				b_op = {{(BW-CW){1'b0}}, col};
			end
			OP_RAY_ROW: begin
				a_op = {coef_row[COEF_W-1], coef_row};
				b_op = {{(BW-CW){1'b0}}, row};
			end
			OP_PP_LL: begin
				a_op = {{(AW-MH){1'b0}}, mag_q[MH-1:0]};
				b_op = {{(BW-DQ_HALF){1'b0}}, dq[DQ_HALF-1:0]};
			end
			OP_PP_LH: begin
				a_op = {{(AW-MH){1'b0}}, mag_q[MH-1:0]};
				b_op = {{(BW-(DQ_W-DQ_HALF)){1'b0}}, dq[DQ_W-1:DQ_HALF]};
			end
			OP_PP_HL: begin
				a_op = {{(AW-(RW-MH)){1'b0}}, mag_q[RW-1:MH]};
				b_op = {{(BW-DQ_HALF){1'b0}}, dq[DQ_HALF-1:0]};
			end
			OP_PP_HH: begin
				a_op = {{(AW-(RW-MH)){1'b0}}, mag_q[RW-1:MH]};
				b_op = {{(BW-(DQ_W-DQ_HALF)){1'b0}}, dq[DQ_W-1:DQ_HALF]};
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod   = a_op * b_op;
	assign pp_ext = {{(PW-PPW){1'b0}}, prod[PPW-1:0]};

	always_comb begin
		case (op)
			OP_PP_LL: pp_add = pp_ext;
			OP_PP_LH: pp_add = pp_ext << DQ_HALF;
			OP_PP_HL: pp_add = pp_ext << MH;
			OP_PP_HH: pp_add = pp_ext << (MH + DQ_HALF);
			default:  pp_add = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_RAY_COL: ray_q <= prod[RW-1:0]
				+ {{(RW-COEF_W){coef_off[COEF_W-1]}}, coef_off};
			OP_RAY_ROW: ray_q <= ray_q + prod[RW-1:0];
			OP_MAG: begin
				neg_q <= ray_q[RW-1];
				mag_q <= ray_q[RW-1] ? (~ray_q + 1'b1) : ray_q;
				pp_q  <= {{(PW-1){1'b0}}, 1'b1} << (ROUND_SHIFT - 1);
			end
			OP_PP_LL, OP_PP_LH, OP_PP_HL, OP_PP_HH: pp_q <= pp_q + pp_add;
			default: ;
		endcase
	end

	// round away from zero already folded in; saturate to 32-bit signed
	assign over = |pp_q[PW-1:ROUND_SHIFT+POINT_W-1];
	assign r_lo = pp_q[ROUND_SHIFT+POINT_W-2:ROUND_SHIFT];

	always_comb begin
		if (neg_q)
			point = over ? {1'b1, {(POINT_W-1){1'b0}}} : (~{1'b0, r_lo} + 1'b1);
		else
			point = over ? {1'b0, {(POINT_W-1){1'b1}}} : {1'b0, r_lo};
	end

endmodule

// ----- rtl/depth_to_point_cloud.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Word
// input     in   in_valid/in_stall   depth_raw, frame_start
// output    out  out_valid/out_stall point_x, point_y, point_z
// config    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each word runs the eight-step microprogram that drives the shared
// multiplier in each of the x and y lanes (ray term, magnitude, four partial
// products, result load). A new word is taken on the last step of the previous.
// A result held by out_stall stretches the last step until the register drains.
// Reset sets counters to zero and registers to their defaults; no clearing pass.

module depth_to_point_cloud import dtpc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [DEPTH_W-1:0]        depth_raw,
	input  logic                      frame_start,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic [POINT_W-1:0]        point_z,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_DIM);
	// wide enough for row_length and for MAX_DIM itself
	localparam int LW = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH = 4'd0,
		REG_X_COL      = 4'd1,
		REG_X_ROW      = 4'd2,
		REG_X_OFF      = 4'd3,
		REG_Y_COL      = 4'd4,
		REG_Y_ROW      = 4'd5,
		REG_Y_OFF      = 4'd6,
		REG_SCALE      = 4'd7
	} cfg_reg_t;

	// Configuration registers
	logic [ROW_LEN_W-1:0]     row_length_q;
	logic signed [COEF_W-1:0] coef_x_col_q, coef_x_row_q, coef_x_off_q;
	logic signed [COEF_W-1:0] coef_y_col_q, coef_y_row_q, coef_y_off_q;
	logic [SCALE_W-1:0]       depth_scale_q;

	// Raster position
	logic [CW-1:0] col_cnt_q, row_cnt_q;
	logic [CW-1:0] pix_col_q, pix_row_q;
	logic [CW-1:0] pix_col_d, pix_row_d;
	logic [LW-1:0] len_eff;
	logic          wrap;

	logic [DQ_W-1:0]   dq_q;		// depth in mm, Q.16
	logic [DQ_W:0]     z_sum;

	logic              accept;
	logic              take_ok;
	logic              out_free;
	seq_ctl_t          ctl;
	logic signed [POINT_W-1:0] lane_x, lane_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q  <= ROW_LEN_W'(640);
			coef_x_col_q  <= '0;
			coef_x_row_q  <= '0;
			coef_x_off_q  <= '0;
			coef_y_col_q  <= '0;
			coef_y_row_q  <= '0;
			coef_y_off_q  <= '0;
			depth_scale_q <= SCALE_W'(65536);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_LENGTH: row_length_q  <= cfg_data[ROW_LEN_W-1:0];
				REG_X_COL:      coef_x_col_q  <= cfg_data;
				REG_X_ROW:      coef_x_row_q  <= cfg_data;
				REG_X_OFF:      coef_x_off_q  <= cfg_data;
				REG_Y_COL:      coef_y_col_q  <= cfg_data;
				REG_Y_ROW:      coef_y_row_q  <= cfg_data;
				REG_Y_OFF:      coef_y_off_q  <= cfg_data;
				REG_SCALE:      depth_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;	// beyond the register list: ignored
			endcase
		end
	end

	// Handshake: the input side is free when idle or on the last step with
	// the result register able to take the finished word.
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !take_ok;
	assign accept   = in_valid && take_ok;

	// Frame start clears the position before this pixel uses it.
	assign pix_col_d = frame_start ? '0 : col_cnt_q;
	assign pix_row_d = frame_start ? '0 : row_cnt_q;

	// Zero row length acts as one, anything above MAX_DIM as MAX_DIM.
	always_comb begin
		if (row_length_q == '0)
			len_eff = LW'(1);
		else if (LW'(row_length_q) > LW'(MAX_DIM))
			len_eff = LW'(MAX_DIM);
		else
			len_eff = LW'(row_length_q);
	end

	assign wrap = (LW'(pix_col_d) + LW'(1)) >= len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_cnt_q <= '0;
				// row saturates until the next frame start
				if (pix_row_d < CW'(MAX_DIM - 1))
					row_cnt_q <= pix_row_d + 1'b1;
				else
					row_cnt_q <= pix_row_d;
			end else begin
				col_cnt_q <= pix_col_d + 1'b1;
				row_cnt_q <= pix_row_d;
			end
		end
	end

	// Per-word operands, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_col_q <= pix_col_d;
			pix_row_q <= pix_row_d;
			dq_q      <= DQ_W'(depth_raw * depth_scale_q);
		end
	end

	dtpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.take_ok  (take_ok),
		.ctl      (ctl)
	);

	dtpc_lane #(.CW(CW)) u_lane_x (
		.clk      (clk),
		.op       (ctl.op),
		.coef_col (coef_x_col_q),
		.coef_row (coef_x_row_q),
		.coef_off (coef_x_off_q),
		.col      (pix_col_q),
		.row      (pix_row_q),
		.dq       (dq_q),
		.point    (lane_x)
	);

	dtpc_lane #(.CW(CW)) u_lane_y (
		.clk      (clk),
		.op       (ctl.op),
		.coef_col (coef_y_col_q),
		.coef_row (coef_y_row_q),
		.coef_off (coef_y_off_q),
		.col      (pix_col_q),
		.row      (pix_row_q),
		.dq       (dq_q),
		.point    (lane_y)
	);

	// z: Q.16 depth rounded half up to Q.8, always fits
	assign z_sum = {1'b0, dq_q} + (DQ_W + 1)'(Z_HALF);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			point_x <= lane_x;
			point_y <= lane_y;
			point_z <= z_sum[Z_DROP+POINT_W-1:Z_DROP];
		end
	end

endmodule

// ----- tb/tb_depth_to_point_cloud.sv -----
`timescale 1ns / 1ps

module tb_depth_to_point_cloud;
	import dtpc_pkg::*;

	// Register map of the configuration channel; indexes past the list are
	// spare and a write to them must leave every register untouched.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH  = 4'd0,
		REG_X_COL       = 4'd1,
		REG_X_ROW       = 4'd2,
		REG_X_OFF       = 4'd3,
		REG_Y_COL       = 4'd4,
		REG_Y_ROW       = 4'd5,
		REG_Y_OFF       = 4'd6,
		REG_DEPTH_SCALE = 4'd7,
		REG_SPARE_LO    = 4'd8,
		REG_SPARE_HI    = 4'd15
	} reg_idx_t;

	typedef struct packed {
		logic [POINT_W-1:0] x;
		logic [POINT_W-1:0] y;
		logic [POINT_W-1:0] z;
	} point_t;

	// Directed stimulus: either a register write or a pixel word. A pixel
	// with pinned set carries a hand-worked result instead of a predicted one.
	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		reg_idx_t           idx;
		logic [31:0]        data;
		logic [DEPTH_W-1:0] depth;
		logic               fs;
		logic               pinned;
		point_t             pt;
	} dir_row_t;

	localparam int SETTLE_CYCLES  = 24;	// lets the datapath settle after draining
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 113;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [DEPTH_W-1:0]        depth_raw;
	logic                      frame_start;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic [POINT_W-1:0]        point_z;
	logic                      cfg_valid;
	logic                      cfg_ready;
	reg_idx_t                  cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// Pinned result travels with the pixel word, driven on the same edges
	logic                      pin_on;
	point_t                    pin_pt;

	depth_to_point_cloud u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.depth_raw  (depth_raw),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block: registers and pixel counters
	// ------------------------------------------------------------------
	logic [ROW_LEN_W-1:0]     row_len_q     = 13'd640;
	logic signed [COEF_W-1:0] k_x_col       = '0;
	logic signed [COEF_W-1:0] k_x_row       = '0;
	logic signed [COEF_W-1:0] k_x_off       = '0;
	logic signed [COEF_W-1:0] k_y_col       = '0;
	logic signed [COEF_W-1:0] k_y_row       = '0;
	logic signed [COEF_W-1:0] k_y_off       = '0;
	logic [SCALE_W-1:0]       depth_scale_q = 24'h01_0000;	// 1.0 mm per unit
	int                       col_cnt       = 0;
	int                       row_cnt       = 0;

	point_t point_q[$];	// points still owed by the block, oldest first

	int pixels_in    = 0;
	int frames_seen  = 0;
	int points_out   = 0;
	int writes_seen  = 0;
	int clipped      = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	bit jitter_on    = 1'b0;

	// Ray term (Q.28) times depth in mm (Q.16) gives Q.44; round to Q.8 with
	// halves going away from zero, then clip to the signed 32-bit range.
	function automatic logic [POINT_W-1:0] ray_to_mm(input longint ray,
			input logic [DQ_W-1:0] dq);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] q8;
		mag  = (ray < 0) ? 64'(-ray) : 64'(ray);
		prod = {64'd0, mag} * {{(128 - DQ_W){1'b0}}, dq};
		q8   = (prod + (128'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		if (ray < 0) begin
			if (q8 >= 128'(SAT_NEG))
				return SAT_NEG;
			return ~q8[POINT_W-1:0] + 1'b1;
		end
		if (q8 > 128'(SAT_POS))
			return SAT_POS;
		return q8[POINT_W-1:0];
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("point %0d %s: expected %h, got %h", points_out, what, want, got);
	endtask

	// ------------------------------------------------------------------
	// Monitor: register writes, accepted pixels, accepted points, watchdog.
	// Everything is sampled at the clock edge, before any update of it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		point_t             want;
		longint             ray_x;
		longint             ray_y;
		logic [DQ_W-1:0]    dq;
		logic [DQ_W:0]      z_sum;
		int                 len;
		bit                 moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				writes_seen++;
				case (cfg_index)
					REG_ROW_LENGTH:  row_len_q     = cfg_data[ROW_LEN_W-1:0];
					REG_X_COL:       k_x_col       = cfg_data;
					REG_X_ROW:       k_x_row       = cfg_data;
					REG_X_OFF:       k_x_off       = cfg_data;
					REG_Y_COL:       k_y_col       = cfg_data;
					REG_Y_ROW:       k_y_row       = cfg_data;
					REG_Y_OFF:       k_y_off       = cfg_data;
					REG_DEPTH_SCALE: depth_scale_q = cfg_data[SCALE_W-1:0];
					default: ;	// spare index: no register changes
				endcase
			end

			if (in_valid && !in_stall) begin
				moved = 1'b1;
				pixels_in++;
				// frame start clears both counters before the pixel is used
				if (frame_start) begin
					col_cnt = 0;
					row_cnt = 0;
					frames_seen++;
				end
				ray_x = longint'(k_x_col) * col_cnt + longint'(k_x_row) * row_cnt
					+ longint'(k_x_off);
				ray_y = longint'(k_y_col) * col_cnt + longint'(k_y_row) * row_cnt
					+ longint'(k_y_off);
				dq    = {{SCALE_W{1'b0}}, depth_raw} * {{DEPTH_W{1'b0}}, depth_scale_q};
				z_sum = {1'b0, dq} + (DQ_W + 1)'(Z_HALF);	// z rounds half up
				want.x = ray_to_mm(ray_x, dq);
				want.y = ray_to_mm(ray_y, dq);
				want.z = z_sum[Z_DROP +: POINT_W];
				if (pin_on)
					want = pin_pt;
				point_q.push_back(want);

				// zero row length behaves as one, oversize as the maximum;
				// the row counter sticks at its top value until a frame start
				len = int'(row_len_q);
				if (len == 0)
					len = 1;
				if (len > MAX_DIM_DEF)
					len = MAX_DIM_DEF;
				if (col_cnt + 1 >= len) begin
					col_cnt = 0;
					if (row_cnt < MAX_DIM_DEF - 1)
						row_cnt++;
				end else begin
					col_cnt++;
				end
			end

			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (point_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("point %0d arrived with none owed: %h %h %h",
							points_out, point_x, point_y, point_z);
				end else begin
					want = point_q.pop_front();
					if (want.x == SAT_POS || want.x == SAT_NEG)
						clipped++;
					if (want.y == SAT_POS || want.y == SAT_NEG)
						clipped++;
					if (point_x !== want.x)
						note_mismatch("x", want.x, point_x);
					if (point_y !== want.y)
						note_mismatch("y", want.y, point_y);
					if (point_z !== want.z)
						note_mismatch("z", want.z, point_z);
				end
				points_out++;
			end
		end

		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d points owed",
				quiet_cycles, point_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver back-pressure: out_stall held high in bursts that start at random
	always @(posedge clk) begin : sink_stall
		int stall_left;
		if (!arst_n || !jitter_on) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_stall  <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic push_pixel(input logic [DEPTH_W-1:0] d, input logic fs,
			input logic pin, input point_t pt);
		cfg_valid <= 1'b0;
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		depth_raw   <= d;
		frame_start <= fs;
		pin_on      <= pin;
		pin_pt      <= pt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the next pixel word lowers it
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Hold the sender until every owed point is back, then let the
	// datapath settle before anything touches the registers
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (point_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic dir_row_t wr(input reg_idx_t idx, input logic [31:0] data);
		dir_row_t r;
		r = '{kind: ROW_WRITE, idx: idx, data: data, depth: '0, fs: 1'b0,
			pinned: 1'b0, pt: '0};
		return r;
	endfunction

	function automatic dir_row_t pin(input logic [DEPTH_W-1:0] d, input logic fs,
			input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez);
		dir_row_t r;
		r = '{kind: ROW_PIXEL, idx: REG_ROW_LENGTH, data: '0, depth: d, fs: fs,
			pinned: 1'b1, pt: '{x: ex, y: ey, z: ez}};
		return r;
	endfunction

	function automatic dir_row_t pix(input logic [DEPTH_W-1:0] d, input logic fs);
		dir_row_t r;
		r = '{kind: ROW_PIXEL, idx: REG_ROW_LENGTH, data: '0, depth: d, fs: fs,
			pinned: 1'b0, pt: '0};
		return r;
	endfunction

	// Register value for a phase: mode 0 all at the top, mode 1 all at the
	// bottom, anything else a random mix leaning towards sensible cameras
	function automatic logic [31:0] setting_for(input reg_idx_t r, input int mode);
		int v;
		case (r)
			REG_ROW_LENGTH: begin
				if (mode == 0)
					return 32'h0000_1FFF;
				if (mode == 1)
					return 32'd0;
				case ($urandom_range(0, 7))
					0: return 32'd0;
					1: return MAX_DIM_DEF;
					2: return 32'd640;
					3: return $urandom();
					default: return $urandom_range(1, 12);
				endcase
			end
			REG_DEPTH_SCALE: begin
				if (mode == 0)
					return 32'h00FF_FFFF;
				if (mode == 1)
					return 32'd0;
				case ($urandom_range(0, 6))
					0: return 32'd0;
					1: return 32'h00FF_FFFF;
					2: return $urandom();
					3: return 32'h0001_0000;
					default: return $urandom_range(256, 1 << 20);
				endcase
			end
			default: begin
				if (mode == 0)
					return SAT_POS;
				if (mode == 1)
					return SAT_NEG;
				case ($urandom_range(0, 9))
					0: return 32'd0;
					1: return SAT_POS;
					2: return SAT_NEG;
					3, 4: return $urandom();
					5: begin
						v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
						return v;
					end
					default: begin
						v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
						return v;
					end
				endcase
			end
		endcase
	endfunction

	function automatic logic [DEPTH_W-1:0] pick_depth();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		dir_row_t dir_tab[$];
		int       ph;
		int       i;
		int       r;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		depth_raw   = '0;
		frame_start = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_ROW_LENGTH;
		cfg_data    = '0;
		pin_on      = 1'b0;
		pin_pt      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		jitter_on = 1'b1;

		// --- directed part ---
		// out of reset: zero ray coefficients, unit scale, so z = depth << 8
		dir_tab.push_back(pin(16'h0000, 1'b1, 32'd0, 32'd0, 32'd0));
		dir_tab.push_back(pin(16'hFFFF, 1'b0, 32'd0, 32'd0, 32'h00FF_FF00));
		dir_tab.push_back(pin(16'h0001, 1'b0, 32'd0, 32'd0, 32'h0000_0100));
		// writes past the register list change nothing
		dir_tab.push_back(wr(REG_SPARE_LO, 32'hFFFF_FFFF));
		dir_tab.push_back(wr(REG_SPARE_HI, 32'h1234_5678));
		dir_tab.push_back(pin(16'h8000, 1'b0, 32'd0, 32'd0, 32'h0080_0000));
		// full scale and extreme offsets: x and y clip both ways
		dir_tab.push_back(wr(REG_DEPTH_SCALE, 32'h00FF_FFFF));
		dir_tab.push_back(wr(REG_X_OFF, SAT_POS));
		dir_tab.push_back(wr(REG_Y_OFF, SAT_NEG));
		dir_tab.push_back(pin(16'hFFFF, 1'b1, SAT_POS, SAT_NEG, 32'hFFFE_FF00));
		dir_tab.push_back(pin(16'h0000, 1'b0, 32'd0, 32'd0, 32'd0));
		// product of exactly half an LSB: x rounds up, y rounds down to -1
		dir_tab.push_back(wr(REG_DEPTH_SCALE, 32'h0010_0000));
		dir_tab.push_back(wr(REG_X_OFF, 32'h0000_0001));
		dir_tab.push_back(wr(REG_Y_OFF, 32'hFFFF_FFFF));
		dir_tab.push_back(pin(16'h8000, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0800_0000));
		// z half rounds up, ray terms stay below half
		dir_tab.push_back(wr(REG_DEPTH_SCALE, 32'd128));
		dir_tab.push_back(pin(16'h0001, 1'b0, 32'd0, 32'd0, 32'h0000_0001));
		// geometry: column and row weights, then the row length corners
		dir_tab.push_back(wr(REG_DEPTH_SCALE, 32'h0001_0000));
		dir_tab.push_back(wr(REG_X_COL, 32'h1000_0000));
		dir_tab.push_back(wr(REG_X_ROW, 32'hF800_0000));
		dir_tab.push_back(wr(REG_Y_COL, 32'h0000_0003));
		dir_tab.push_back(wr(REG_Y_ROW, 32'h1000_0000));
		dir_tab.push_back(wr(REG_ROW_LENGTH, 32'd0));	// wraps every pixel
		dir_tab.push_back(pix(16'd100, 1'b1));
		dir_tab.push_back(pix(16'd200, 1'b0));
		dir_tab.push_back(pix(16'd300, 1'b0));
		dir_tab.push_back(pix(16'd400, 1'b0));
		dir_tab.push_back(wr(REG_ROW_LENGTH, 32'hFFFF_0003));	// upper bits dropped
		dir_tab.push_back(pix(16'd500, 1'b1));
		dir_tab.push_back(pix(16'd600, 1'b0));
		dir_tab.push_back(pix(16'd700, 1'b0));
		dir_tab.push_back(pix(16'd800, 1'b0));
		dir_tab.push_back(pix(16'd900, 1'b1));	// frame start in mid row
		dir_tab.push_back(pix(16'd1000, 1'b0));
		dir_tab.push_back(wr(REG_ROW_LENGTH, 32'h0000_1FFF));	// clamps to maximum
		dir_tab.push_back(pix(16'hFFFF, 1'b1));
		dir_tab.push_back(pix(16'hFFFF, 1'b0));

		foreach (dir_tab[k]) begin
			if (dir_tab[k].kind == ROW_WRITE) begin
				if (k == 0 || dir_tab[k-1].kind != ROW_WRITE)
					wait_drained();
				write_reg(dir_tab[k].idx, dir_tab[k].data);
			end else begin
				push_pixel(dir_tab[k].depth, dir_tab[k].fs, dir_tab[k].pinned,
					dir_tab[k].pt);
			end
		end

		// --- random phases, each under a fresh register setting ---
		// first two phases pin every register to an extreme; the last two
		// and every fourth run without any idling
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			jitter_on = (ph < RANDOM_PHASES - 2) && (ph % 4 != 3);
			for (r = REG_ROW_LENGTH; r <= REG_DEPTH_SCALE; r++)
				write_reg(reg_idx_t'(r), setting_for(reg_idx_t'(r), ph));
			if ($urandom_range(0, 2) == 0)
				write_reg(reg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					$urandom());
			// well-formed frames, with the odd stray frame start as noise
			for (i = 0; i < PHASE_ITEMS; i++)
				push_pixel(pick_depth(), (i == 0) || ($urandom_range(0, 39) == 0),
					1'b0, '0);
		end

		jitter_on = 1'b0;
		wait_drained();

		if (point_q.size() != 0) begin
			mismatches += point_q.size();
			$display("%0d points never came out", point_q.size());
		end
		$display("Ran %0d pixels over %0d frames with %0d register writes;",
			pixels_in, frames_seen, writes_seen);
		$display("%0d points checked, %0d coordinates clipped, %0d mismatches.",
			points_out, clipped, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dtpc_pkg.sv
rtl/dtpc_seq.sv
rtl/dtpc_lane.sv
rtl/depth_to_point_cloud.sv
tb/tb_depth_to_point_cloud.sv
